@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also watches reset itself.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/hcr_pkg.sv @@
// Types, constants, entity table and UTF-8 helpers for the character reference decoder.
package hcr_pkg;

    localparam int NAME_W     = 64;
    localparam int NAME_LEN_W = 4;
    localparam int ENT_IDX_W  = 9;
    localparam int CP_W       = 21;
    localparam int TAB_NAME_BYTES = 8;

    localparam logic [CP_W-1:0] CODE_MAX = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;

    typedef enum logic [1:0] {
        KIND_NAMED = 2'd0,
        KIND_DEC   = 2'd1,
        KIND_HEX   = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_FAIL = 2'd0,
        OP_CODE = 2'd1,
        OP_NAME = 2'd2
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [NAME_W-1:0]     name;
        logic [NAME_LEN_W-1:0] len;
        logic [CP_W-1:0]       cp;
    } t_job;

    typedef struct packed {
        logic [NAME_W-1:0] nm;
        logic [CP_W-1:0]   cp;
    } t_ent;

    // Names are right-justified: the final character sits in the lowest byte.
    function automatic t_ent ent_rom(input logic [ENT_IDX_W-1:0] idx);
        t_ent e;
        e = '{64'd0, 21'd0};
        case (idx)
            9'd0: e = '{"quot", 21'h22};     9'd1: e = '{"amp", 21'h26};
            9'd2: e = '{"apos", 21'h27};     9'd3: e = '{"lt", 21'h3c};
            9'd4: e = '{"gt", 21'h3e};       9'd5: e = '{"nbsp", 21'ha0};
            9'd6: e = '{"iexcl", 21'ha1};    9'd7: e = '{"cent", 21'ha2};
            9'd8: e = '{"pound", 21'ha3};    9'd9: e = '{"curren", 21'ha4};
            9'd10: e = '{"yen", 21'ha5};     9'd11: e = '{"brvbar", 21'ha6};
            9'd12: e = '{"sect", 21'ha7};    9'd13: e = '{"uml", 21'ha8};
            9'd14: e = '{"copy", 21'ha9};    9'd15: e = '{"ordf", 21'haa};
            9'd16: e = '{"laquo", 21'hab};   9'd17: e = '{"not", 21'hac};
            9'd18: e = '{"shy", 21'had};     9'd19: e = '{"reg", 21'hae};
            9'd20: e = '{"macr", 21'haf};    9'd21: e = '{"deg", 21'hb0};
            9'd22: e = '{"plusmn", 21'hb1};  9'd23: e = '{"sup2", 21'hb2};
            9'd24: e = '{"sup3", 21'hb3};    9'd25: e = '{"acute", 21'hb4};
            9'd26: e = '{"micro", 21'hb5};   9'd27: e = '{"para", 21'hb6};
            9'd28: e = '{"middot", 21'hb7};  9'd29: e = '{"cedil", 21'hb8};
            9'd30: e = '{"sup1", 21'hb9};    9'd31: e = '{"ordm", 21'hba};
            9'd32: e = '{"raquo", 21'hbb};   9'd33: e = '{"frac14", 21'hbc};
            9'd34: e = '{"frac12", 21'hbd};  9'd35: e = '{"frac34", 21'hbe};
            9'd36: e = '{"iquest", 21'hbf};  9'd37: e = '{"Agrave", 21'hc0};
            9'd38: e = '{"Aacute", 21'hc1};  9'd39: e = '{"Acirc", 21'hc2};
            9'd40: e = '{"Atilde", 21'hc3};  9'd41: e = '{"Auml", 21'hc4};
            9'd42: e = '{"Aring", 21'hc5};   9'd43: e = '{"AElig", 21'hc6};
            9'd44: e = '{"Ccedil", 21'hc7};  9'd45: e = '{"Egrave", 21'hc8};
            9'd46: e = '{"Eacute", 21'hc9};  9'd47: e = '{"Ecirc", 21'hca};
            9'd48: e = '{"Euml", 21'hcb};    9'd49: e = '{"Igrave", 21'hcc};
            9'd50: e = '{"Iacute", 21'hcd};  9'd51: e = '{"Icirc", 21'hce};
            9'd52: e = '{"Iuml", 21'hcf};    9'd53: e = '{"ETH", 21'hd0};
            9'd54: e = '{"Ntilde", 21'hd1};  9'd55: e = '{"Ograve", 21'hd2};
            9'd56: e = '{"Oacute", 21'hd3};  9'd57: e = '{"Ocirc", 21'hd4};
            9'd58: e = '{"Otilde", 21'hd5};  9'd59: e = '{"Ouml", 21'hd6};
            9'd60: e = '{"times", 21'hd7};   9'd61: e = '{"Oslash", 21'hd8};
            9'd62: e = '{"Ugrave", 21'hd9};  9'd63: e = '{"Uacute", 21'hda};
            9'd64: e = '{"Ucirc", 21'hdb};   9'd65: e = '{"Uuml", 21'hdc};
            9'd66: e = '{"Yacute", 21'hdd};  9'd67: e = '{"THORN", 21'hde};
            9'd68: e = '{"szlig", 21'hdf};   9'd69: e = '{"agrave", 21'he0};
            9'd70: e = '{"aacute", 21'he1};  9'd71: e = '{"acirc", 21'he2};
            9'd72: e = '{"atilde", 21'he3};  9'd73: e = '{"auml", 21'he4};
            9'd74: e = '{"aring", 21'he5};   9'd75: e = '{"aelig", 21'he6};
            9'd76: e = '{"ccedil", 21'he7};  9'd77: e = '{"egrave", 21'he8};
            9'd78: e = '{"eacute", 21'he9};  9'd79: e = '{"ecirc", 21'hea};
            9'd80: e = '{"euml", 21'heb};    9'd81: e = '{"igrave", 21'hec};
            9'd82: e = '{"iacute", 21'hed};  9'd83: e = '{"icirc", 21'hee};
            9'd84: e = '{"iuml", 21'hef};    9'd85: e = '{"eth", 21'hf0};
            9'd86: e = '{"ntilde", 21'hf1};  9'd87: e = '{"ograve", 21'hf2};
            9'd88: e = '{"oacute", 21'hf3};  9'd89: e = '{"ocirc", 21'hf4};
            9'd90: e = '{"otilde", 21'hf5};  9'd91: e = '{"ouml", 21'hf6};
            9'd92: e = '{"divide", 21'hf7};  9'd93: e = '{"oslash", 21'hf8};
            9'd94: e = '{"ugrave", 21'hf9};  9'd95: e = '{"uacute", 21'hfa};
            9'd96: e = '{"ucirc", 21'hfb};   9'd97: e = '{"uuml", 21'hfc};
            9'd98: e = '{"yacute", 21'hfd};  9'd99: e = '{"thorn", 21'hfe};
            9'd100: e = '{"yuml", 21'hff};   9'd101: e = '{"OElig", 21'h152};
            9'd102: e = '{"oelig", 21'h153}; 9'd103: e = '{"Scaron", 21'h160};
            9'd104: e = '{"scaron", 21'h161}; 9'd105: e = '{"Yuml", 21'h178};
            9'd106: e = '{"fnof", 21'h192};  9'd107: e = '{"circ", 21'h2c6};
            9'd108: e = '{"tilde", 21'h2dc}; 9'd109: e = '{"Alpha", 21'h391};
            9'd110: e = '{"Beta", 21'h392};  9'd111: e = '{"Gamma", 21'h393};
            9'd112: e = '{"Delta", 21'h394}; 9'd113: e = '{"Epsilon", 21'h395};
            9'd114: e = '{"Zeta", 21'h396};  9'd115: e = '{"Eta", 21'h397};
            9'd116: e = '{"Theta", 21'h398}; 9'd117: e = '{"Iota", 21'h399};
            9'd118: e = '{"Kappa", 21'h39a}; 9'd119: e = '{"Lambda", 21'h39b};
            9'd120: e = '{"Mu", 21'h39c};    9'd121: e = '{"Nu", 21'h39d};
            9'd122: e = '{"Xi", 21'h39e};    9'd123: e = '{"Omicron", 21'h39f};
            9'd124: e = '{"Pi", 21'h3a0};    9'd125: e = '{"Rho", 21'h3a1};
            9'd126: e = '{"Sigma", 21'h3a3}; 9'd127: e = '{"Tau", 21'h3a4};
            9'd128: e = '{"Upsilon", 21'h3a5}; 9'd129: e = '{"Phi", 21'h3a6};
            9'd130: e = '{"Chi", 21'h3a7};   9'd131: e = '{"Psi", 21'h3a8};
            9'd132: e = '{"Omega", 21'h3a9}; 9'd133: e = '{"alpha", 21'h3b1};
            9'd134: e = '{"beta", 21'h3b2};  9'd135: e = '{"gamma", 21'h3b3};
            9'd136: e = '{"delta", 21'h3b4}; 9'd137: e = '{"epsilon", 21'h3b5};
            9'd138: e = '{"zeta", 21'h3b6};  9'd139: e = '{"eta", 21'h3b7};
            9'd140: e = '{"theta", 21'h3b8}; 9'd141: e = '{"iota", 21'h3b9};
            9'd142: e = '{"kappa", 21'h3ba}; 9'd143: e = '{"lambda", 21'h3bb};
            9'd144: e = '{"mu", 21'h3bc};    9'd145: e = '{"nu", 21'h3bd};
            9'd146: e = '{"xi", 21'h3be};    9'd147: e = '{"omicron", 21'h3bf};
            9'd148: e = '{"pi", 21'h3c0};    9'd149: e = '{"rho", 21'h3c1};
            9'd150: e = '{"sigmaf", 21'h3c2}; 9'd151: e = '{"sigma", 21'h3c3};
            9'd152: e = '{"tau", 21'h3c4};   9'd153: e = '{"upsilon", 21'h3c5};
            9'd154: e = '{"phi", 21'h3c6};   9'd155: e = '{"chi", 21'h3c7};
            9'd156: e = '{"psi", 21'h3c8};   9'd157: e = '{"omega", 21'h3c9};
            9'd158: e = '{"thetasym", 21'h3d1}; 9'd159: e = '{"upsih", 21'h3d2};
            9'd160: e = '{"piv", 21'h3d6};   9'd161: e = '{"ensp", 21'h2002};
            9'd162: e = '{"emsp", 21'h2003}; 9'd163: e = '{"thinsp", 21'h2009};
            9'd164: e = '{"zwnj", 21'h200c}; 9'd165: e = '{"zwj", 21'h200d};
            9'd166: e = '{"lrm", 21'h200e};  9'd167: e = '{"rlm", 21'h200f};
            9'd168: e = '{"ndash", 21'h2013}; 9'd169: e = '{"mdash", 21'h2014};
            9'd170: e = '{"lsquo", 21'h2018}; 9'd171: e = '{"rsquo", 21'h2019};
            9'd172: e = '{"sbquo", 21'h201a}; 9'd173: e = '{"ldquo", 21'h201c};
            9'd174: e = '{"rdquo", 21'h201d}; 9'd175: e = '{"bdquo", 21'h201e};
            9'd176: e = '{"dagger", 21'h2020}; 9'd177: e = '{"Dagger", 21'h2021};
            9'd178: e = '{"bull", 21'h2022}; 9'd179: e = '{"hellip", 21'h2026};
            9'd180: e = '{"permil", 21'h2030}; 9'd181: e = '{"prime", 21'h2032};
            9'd182: e = '{"Prime", 21'h2033}; 9'd183: e = '{"lsaquo", 21'h2039};
            9'd184: e = '{"rsaquo", 21'h203a}; 9'd185: e = '{"oline", 21'h203e};
            9'd186: e = '{"frasl", 21'h2044}; 9'd187: e = '{"euro", 21'h20ac};
            9'd188: e = '{"image", 21'h2111}; 9'd189: e = '{"weierp", 21'h2118};
            9'd190: e = '{"real", 21'h211c}; 9'd191: e = '{"trade", 21'h2122};
            9'd192: e = '{"alefsym", 21'h2135}; 9'd193: e = '{"larr", 21'h2190};
            9'd194: e = '{"uarr", 21'h2191}; 9'd195: e = '{"rarr", 21'h2192};
            9'd196: e = '{"darr", 21'h2193}; 9'd197: e = '{"harr", 21'h2194};
            9'd198: e = '{"crarr", 21'h21b5}; 9'd199: e = '{"lArr", 21'h21d0};
            9'd200: e = '{"uArr", 21'h21d1}; 9'd201: e = '{"rArr", 21'h21d2};
            9'd202: e = '{"dArr", 21'h21d3}; 9'd203: e = '{"hArr", 21'h21d4};
            9'd204: e = '{"forall", 21'h2200}; 9'd205: e = '{"part", 21'h2202};
            9'd206: e = '{"exist", 21'h2203}; 9'd207: e = '{"empty", 21'h2205};
            9'd208: e = '{"nabla", 21'h2207}; 9'd209: e = '{"isin", 21'h2208};
            9'd210: e = '{"notin", 21'h2209}; 9'd211: e = '{"ni", 21'h220b};
            9'd212: e = '{"prod", 21'h220f}; 9'd213: e = '{"sum", 21'h2211};
            9'd214: e = '{"minus", 21'h2212}; 9'd215: e = '{"lowast", 21'h2217};
            9'd216: e = '{"radic", 21'h221a}; 9'd217: e = '{"prop", 21'h221d};
            9'd218: e = '{"infin", 21'h221e}; 9'd219: e = '{"ang", 21'h2220};
            9'd220: e = '{"and", 21'h2227};  9'd221: e = '{"or", 21'h2228};
            9'd222: e = '{"cap", 21'h2229};  9'd223: e = '{"cup", 21'h222a};
            9'd224: e = '{"int", 21'h222b};  9'd225: e = '{"there4", 21'h2234};
            9'd226: e = '{"sim", 21'h223c};  9'd227: e = '{"cong", 21'h2245};
            9'd228: e = '{"asymp", 21'h2248}; 9'd229: e = '{"ne", 21'h2260};
            9'd230: e = '{"equiv", 21'h2261}; 9'd231: e = '{"le", 21'h2264};
            9'd232: e = '{"ge", 21'h2265};   9'd233: e = '{"sub", 21'h2282};
            9'd234: e = '{"sup", 21'h2283};  9'd235: e = '{"nsub", 21'h2284};
            9'd236: e = '{"sube", 21'h2286}; 9'd237: e = '{"supe", 21'h2287};
            9'd238: e = '{"oplus", 21'h2295}; 9'd239: e = '{"otimes", 21'h2297};
            9'd240: e = '{"perp", 21'h22a5}; 9'd241: e = '{"sdot", 21'h22c5};
            9'd242: e = '{"lceil", 21'h2308}; 9'd243: e = '{"rceil", 21'h2309};
            9'd244: e = '{"lfloor", 21'h230a}; 9'd245: e = '{"rfloor", 21'h230b};
            9'd246: e = '{"lang", 21'h2329}; 9'd247: e = '{"rang", 21'h232a};
            9'd248: e = '{"loz", 21'h25ca};  9'd249: e = '{"spades", 21'h2660};
            9'd250: e = '{"clubs", 21'h2663}; 9'd251: e = '{"hearts", 21'h2665};
            9'd252: e = '{"diams", 21'h2666}; 9'd253: e = '{"QUOT", 21'h22};
            9'd254: e = '{"AMP", 21'h26};    9'd255: e = '{"COPY", 21'ha9};
            9'd256: e = '{"GT", 21'h3e};     9'd257: e = '{"LT", 21'h3c};
            9'd258: e = '{"REG", 21'hae};
            default: e = '{64'd0, 21'd0};
        endcase
        return e;
    endfunction

    // Count of name bytes; table names hold no zero byte.
    function automatic logic [NAME_LEN_W-1:0] ent_len(input logic [NAME_W-1:0] nm);
        logic [NAME_LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < TAB_NAME_BYTES; i++) begin
            if (nm[8*i +: 8] != 8'd0) begin
                n = n + 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
        logic [2:0] n;
        if (cp < 21'h80) begin
            n = 3'd1;
        end else if (cp < 21'h800) begin
            n = 3'd2;
        end else if (cp < 21'h10000) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte_at(input logic [CP_W-1:0] cp,
                                                input logic [1:0] k);
        logic [7:0] b [4];
        b[0] = 8'h00;
        b[1] = 8'h00;
        b[2] = 8'h00;
        b[3] = 8'h00;
        if (cp < 21'h80) begin
            b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
        end else begin
            b[0] = {5'b11110, cp[20:18]};
            b[1] = {2'b10, cp[17:12]};
            b[2] = {2'b10, cp[11:6]};
            b[3] = {2'b10, cp[5:0]};
        end
        return b[k];
    endfunction

endpackage

@@ rtl/core/hcr_ifs.sv @@
// Valid/ready channel interfaces for reference bytes in and UTF-8 bytes out.
interface hcr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] body_char;
    logic       last_char;

    modport source (output valid, output kind, output body_char, output last_char,
                    input ready);
    modport sink   (input valid, input kind, input body_char, input last_char,
                    output ready);
endinterface

interface hcr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] utf8_byte;
    logic       produced;
    logic       last_byte;

    modport source (output valid, output utf8_byte, output produced, output last_byte,
                    input ready);
    modport sink   (input valid, input utf8_byte, input produced, input last_byte,
                    output ready);
endinterface

@@ rtl/core/hcr_front.sv @@
// Front end: takes reference bytes, gathers name or number, classifies at the last byte.
module hcr_front #(
    parameter int MAX_NAME_BYTES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hcr_in_if.sink        i_in,
    input  logic          i_job_room,
    output logic          o_push,
    output hcr_pkg::t_job o_job
);
    import hcr_pkg::*;

    localparam int BUF_W = 8 * MAX_NAME_BYTES;
    localparam int LEN_W = $clog2(MAX_NAME_BYTES + 1);

    logic [BUF_W-1:0] r_name, n_name;
    logic [LEN_W-1:0] r_len, n_len;
    logic [CP_W-1:0]  r_acc, n_acc;
    logic             r_bad, n_bad;

    logic        accept;
    logic [3:0]  dval;
    logic        dok;
    logic [24:0] mul_v;
    t_kind       kind;
    logic [7:0]  ch;

    assign i_in.ready = i_job_room;
    assign accept     = i_in.valid && i_job_room;
    assign o_push     = accept && i_in.last_char;
    assign kind       = t_kind'(i_in.kind);
    assign ch         = i_in.body_char;

    always_comb begin
        dval = 4'd0;
        dok  = 1'b0;
        if (ch >= "0" && ch <= "9") begin
            dval = 4'(ch - "0");
            dok  = 1'b1;
        end else if (kind == KIND_HEX && ch >= "a" && ch <= "f") begin
            dval = 4'(ch - "a" + 8'd10);
            dok  = 1'b1;
        end else if (kind == KIND_HEX && ch >= "A" && ch <= "F") begin
            dval = 4'(ch - "A" + 8'd10);
            dok  = 1'b1;
        end
    end

    // times ten as shift and add, times sixteen as shift
    always_comb begin
        if (kind == KIND_HEX) begin
            mul_v = {r_acc, 4'b0} + 25'(dval);
        end else begin
            mul_v = 25'({r_acc, 3'b0}) + 25'({r_acc, 1'b0}) + 25'(dval);
        end
    end

    always_comb begin
        n_name = r_name;
        n_len  = r_len;
        n_acc  = r_acc;
        n_bad  = r_bad;
        case (kind)
            KIND_NAMED: begin
                if (r_len < LEN_W'(MAX_NAME_BYTES)) begin
                    n_name = {r_name[BUF_W-9:0], ch};
                    n_len  = r_len + 1'b1;
                end else begin
                    n_bad = 1'b1;
                end
            end
            KIND_DEC, KIND_HEX: begin
                if (!dok) begin
                    n_bad = 1'b1;
                end else if (!r_bad) begin
                    if (mul_v > 25'(CODE_MAX)) begin
                        n_bad = 1'b1;
                    end else begin
                        n_acc = mul_v[CP_W-1:0];
                    end
                end
            end
            default: n_bad = 1'b1;
        endcase
    end

    always_comb begin
        o_job.name = n_name[NAME_W-1:0];
        o_job.len  = NAME_LEN_W'(n_len);
        o_job.cp   = n_acc;
        if (n_bad) begin
            o_job.op = OP_FAIL;
        end else if (kind == KIND_NAMED) begin
            o_job.op = (n_len > LEN_W'(TAB_NAME_BYTES)) ? OP_FAIL : OP_NAME;
        end else if (n_acc >= SURR_LO && n_acc <= SURR_HI) begin
            o_job.op = OP_FAIL;
        end else begin
            o_job.op = OP_CODE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name <= '0;
            r_len  <= '0;
            r_acc  <= '0;
            r_bad  <= 1'b0;
        end else if (accept) begin
            if (i_in.last_char) begin
                r_name <= '0;
                r_len  <= '0;
                r_acc  <= '0;
                r_bad  <= 1'b0;
            end else begin
                r_name <= n_name;
                r_len  <= n_len;
                r_acc  <= n_acc;
                r_bad  <= n_bad;
            end
        end
    end

endmodule

@@ rtl/core/hcr_queue.sv @@
// Two-entry job queue between front and back ends.
module hcr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hcr_pkg::t_job i_job,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_pop,
    output hcr_pkg::t_job o_job
);
    import hcr_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_room  = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/core/hcr_back.sv @@
// Back end: table search for names, then UTF-8 emission through an output register.
module hcr_back #(
    parameter int TABLE_ENTRIES = 259
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  hcr_pkg::t_job i_job,
    output logic          o_pop,
    hcr_out_if.source     o_out
);
    import hcr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    t_state                r_state;
    logic [IDX_W-1:0]      r_idx;
    logic [NAME_W-1:0]     r_name;
    logic [NAME_LEN_W-1:0] r_len;
    logic [CP_W-1:0]       r_cp;
    logic                  r_fail;
    logic [1:0]            r_k;
    logic                  r_ov;
    logic [7:0]            r_byte;
    logic                  r_prod;
    logic                  r_last;

    t_ent       ent;
    logic       hit;
    logic       idx_end;
    logic       out_free;
    logic       k_end;
    logic [2:0] nbytes;

    assign ent      = ent_rom(ENT_IDX_W'(r_idx));
    assign hit      = (r_len != '0) && (ent_len(ent.nm) == r_len) && (ent.nm == r_name);
    assign idx_end  = (r_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign out_free = !r_ov || o_out.ready;
    assign nbytes   = utf8_len(r_cp);
    assign k_end    = r_fail || ({1'b0, r_k} == nbytes - 3'd1);
    assign o_pop    = (r_state == ST_IDLE) && i_valid;

    assign o_out.valid     = r_ov;
    assign o_out.utf8_byte = r_byte;
    assign o_out.produced  = r_prod;
    assign o_out.last_byte = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_name  <= i_job.name;
                        r_len   <= i_job.len;
                        r_cp    <= i_job.cp;
                        r_fail  <= (i_job.op == OP_FAIL);
                        r_k     <= 2'd0;
                        r_idx   <= '0;
                        r_state <= (i_job.op == OP_NAME) ? ST_SCAN : ST_EMIT;
                    end
                end
                ST_SCAN: begin
                    if (hit) begin
                        r_cp    <= ent.cp;
                        r_fail  <= 1'b0;
                        r_state <= ST_EMIT;
                    end else if (idx_end) begin
                        r_fail  <= 1'b1;
                        r_state <= ST_EMIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_ov   <= 1'b1;
                        r_byte <= r_fail ? 8'h00 : utf8_byte_at(r_cp, r_k);
                        r_prod <= !r_fail;
                        r_last <= k_end;
                        if (k_end) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/html_char_ref_decoder.sv @@
// Top level of the HTML character reference decoder.
//
//  channel | dir | payload                          | transaction
//  i_in    | in  | kind, body_char, last_char       | one reference byte
//  o_out   | out | utf8_byte, produced, last_byte   | one UTF-8 byte or empty marker
//
// Reference bytes are taken one per cycle while the job queue has room.
// A numeric reference passes the job queue and the back end's job registers into the
// output register, then one byte a cycle while o_out is ready; a named reference
// first walks the entity table one entry a cycle, with a single table compare.
// Reset (synchronous, active low) clears the gathered name, number and queue.
// The front end takes bytes during a search or o_out wait until the queue is full.
module html_char_ref_decoder #(
    parameter int MAX_NAME_BYTES = 8,
    parameter int TABLE_ENTRIES  = 259
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcr_in_if.sink    i_in,
    hcr_out_if.source o_out
);
    import hcr_pkg::*;

    // jobs from the front end, one per finished reference
    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic room;
    logic job_valid;

    hcr_front #(
        .MAX_NAME_BYTES(MAX_NAME_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_job_room(room),
        .o_push    (push),
        .o_job     (push_job)
    );

    // hold finished references so the front end need not wait on the search
    hcr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .o_room (room),
        .o_valid(job_valid),
        .i_pop  (pop),
        .o_job  (pop_job)
    );

    // search the table, encode, and drive the output register
    hcr_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(job_valid),
        .i_job  (pop_job),
        .o_pop  (pop),
        .o_out  (o_out)
    );

endmodule

@@ rtl/core/hcr_checker.sv @@
// Port-level checks on the decoder output, bound to the top level.
`include "assert_macros.svh"

module hcr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_produced,
    input logic       i_out_last
);

    `ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !i_out_valid, "output valid after reset")
    `ASSERT_CLK(a_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_out_last), "stalled output changed")
    `ASSERT_CLK(a_empty, i_out_valid && !i_out_produced |-> i_out_last && i_out_byte == 8'h00, "bad empty marker")
    `ASSERT_CLK(a_lead, i_out_valid && i_out_produced && !i_out_last |-> i_out_byte[7] == 1'b1, "ASCII byte not final")
    `ASSERT_CLK(a_tail, i_out_valid && i_out_produced && i_out_last && i_out_byte[7] |-> i_out_byte[7:6] == 2'b10, "final byte not a continuation")

endmodule

bind html_char_ref_decoder hcr_checker u_hcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.utf8_byte),
    .i_out_produced(o_out.produced),
    .i_out_last    (o_out.last_byte)
);
